// ===== sv/cert_pkg.sv =====
// ----------------------------------------------------------------------------
// cert_pkg: shared types and constants
// Register indexes, item modes, phase codes and queue entry type.
// ----------------------------------------------------------------------------
package cert_pkg;

  // register indexes
  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_HYST      = 3'd1;
  localparam logic [2:0] REG_WLEN      = 3'd2;
  localparam logic [2:0] REG_ALPHA     = 3'd3;
  localparam logic [2:0] REG_MIN_DUR   = 3'd4;
  localparam logic [2:0] REG_MAX_DUR   = 3'd5;
  localparam logic [2:0] REG_COOLDOWN  = 3'd6;
  localparam logic [2:0] REG_DC_OFFSET = 3'd7;

  // item modes
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_ON     = 2'd1;
  localparam logic [1:0] MODE_OFF    = 2'd2;
  localparam logic [1:0] MODE_TOGGLE = 2'd3;

  // detector phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DETECT = 2'd1;
  localparam logic [1:0] PH_VALID  = 2'd2;
  localparam logic [1:0] PH_COOL   = 2'd3;

  // classified item passed from front to back
  typedef struct packed {
    logic [1:0]  mode;
    logic [10:0] ac;
    logic [31:0] now_ms;
  } item_t;

endpackage

// ===== sv/clap_envelope_relay_trigger.sv =====
// ----------------------------------------------------------------------------
// clap_envelope_relay_trigger: impulse detector driving one relay
// Moving average, envelope follower and four-phase clap detector.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on s_axis (mode, sample, now_ms); each one gives exactly
// one result on m_axis (relay_out, env_level, phase, toggled).
// Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_data_i while
// idle; the user keeps to this, the block does not enforce it. Any write clears
// the moving-average window. A sample item passes S_RD, S_UPD, S_DIV, S_MUL,
// S_FSM and S_OUT after acceptance; S_DIV is the bit-serial divider that forms
// the window average, one quotient bit a cycle. Manual items go straight to S_OUT.
// One item is processed at a time and the back end starts the next one only
// after the result has been taken. A two-entry input queue keeps accepting
// while the back end works.
// Reset clears the control and detector state, loads register defaults and drops valid outputs.
// When the receiver stalls, the result is held in the output register and
// the back end stops; the queue fills and then s_axis_tready falls.
// ----------------------------------------------------------------------------
module clap_envelope_relay_trigger
  import cert_pkg::*;
#(
  parameter int WINDOW_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // mode
  input  logic [47:0] s_axis_tdata,   // sample[9:0], now_ms[41:10], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // relay_out, env_level, phase, toggled
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [9:0]  dco;
  logic        qv, qpop;
  item_t       qit;
  logic [13:0] od;

  cert_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .mode_i(s_axis_tuser), .sample_i(s_axis_tdata[9:0]),
    .now_i(s_axis_tdata[41:10]), .dc_offset_i(dco),
    .q_valid_o(qv), .q_pop_i(qpop), .q_item_o(qit)
  );

  cert_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .dc_offset_o(dco), .q_valid_i(qv), .q_pop_o(qpop), .q_item_i(qit),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(od)
  );

  assign m_axis_tdata = {2'b00, od};

endmodule

// ===== sv/cert_front.sv =====
// ----------------------------------------------------------------------------
// cert_front: input stage and item queue
// Accepts items, removes the dc offset and buffers them in a short fifo.
// ----------------------------------------------------------------------------
module cert_front
  import cert_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [9:0]  sample_i,
  input  logic [31:0] now_i,
  input  logic [9:0]  dc_offset_i,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output item_t       q_item_o
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      it;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];

  // classify and remove offset
  always_comb begin
    it.mode   = mode_i;
    it.ac     = {1'b0, sample_i} - {1'b0, dc_offset_i};
    it.now_ms = now_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= it;
  end

  // fifo pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

// ===== sv/cert_back.sv =====
// ----------------------------------------------------------------------------
// cert_back: envelope and detector sequencer
// Window update, serial division, envelope mix, phase machine, output reg.
// ----------------------------------------------------------------------------
module cert_back
  import cert_pkg::*;
#(
  parameter int WINDOW_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic [9:0]  dc_offset_o,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  item_t       q_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [13:0] out_data_o
);

  localparam int PW = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
  localparam int SW = 11 + PW + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_RD = 7'b0000010, S_UPD = 7'b0000100,
    S_DIV = 7'b0001000, S_MUL = 7'b0010000, S_FSM = 7'b0100000,
    S_OUT = 7'b1000000
  } state_e;

  state_e state_q;

  // configuration
  logic [9:0]  thr_q, hys_q, dco_q;
  logic [4:0]  wlen_q;
  logic [15:0] alpha_q, mind_q, maxd_q, cool_q;

  // window
  logic [10:0]     win_mem [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] wvld_q;
  logic [10:0]     old_q;
  logic [PW-1:0]   pos_q;
  logic [SW-1:0]   sum_q;

  // item and datapath
  item_t           it_q;
  logic [SW-1:0]   dvd_q;
  logic [SW-1:0]   quo_q;
  logic [SW:0]     rem_q;
  logic [5:0]      dcnt_q;
  logic [25:0]     env_q;
  logic [42:0]     p1_q, p2_q;

  // detector
  logic [1:0]  ph_q;
  logic [31:0] start_q, last_q;
  logic [9:0]  peak_q;
  logic [25:0] total_q;
  logic [15:0] len_q;
  logic        relay_q, tog_q;
  logic        ov_q;
  logic [13:0] od_q;

  logic [6:0]  elen;
  logic [PW:0] lenw;
  logic [9:0]  lvl, lo;
  logic [10:0] hi;
  logic [31:0] dur, age;
  logic        guard, cmp_ok;
  logic [SW:0] trial;
  logic [SW-1:0] sum_new;
  logic [33:0] lhs;
  logic [28:0] rhs;
  logic [32:0] g100;

  assign dc_offset_o = dco_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i && !ov_q;

  // effective window length
  always_comb begin
    elen = {2'b0, wlen_q};
    if (wlen_q < 5'd2) elen = 7'd2;
    if ({2'b0, wlen_q} > 7'(WINDOW_MAX)) elen = 7'(WINDOW_MAX);
    lenw = elen[PW:0];
  end

  assign lvl   = env_q[25:16];
  assign hi    = {1'b0, thr_q} + {1'b0, hys_q};
  assign lo    = (thr_q > hys_q) ? thr_q - hys_q : 10'd0;
  assign dur   = it_q.now_ms - start_q;
  assign age   = it_q.now_ms - last_q;
  // 100 * total as 64 + 32 + 4
  assign g100  = {1'b0, total_q, 6'd0} + {2'd0, total_q, 5'd0} + {5'd0, total_q, 2'd0};
  assign guard = g100 > {17'd0, len_q};
  assign lhs   = {7'd0, {16'd0, peak_q} * {10'd0, len_q}, 1'b0};
  assign rhs   = {1'b0, total_q, 2'b0} + {3'd0, total_q};
  assign cmp_ok = lhs > {5'd0, rhs};
  assign trial = {rem_q[SW-1:0], dvd_q[SW-1]} - {{(SW-PW){1'b0}}, lenw};

  // running window sum after replacing the oldest entry
  assign sum_new = sum_q - (wvld_q[pos_q] ? {{(SW-11){old_q[10]}}, old_q} : '0)
                   + {{(SW-11){it_q.ac[10]}}, it_q.ac};

  // window store
  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) win_mem[pos_q] <= it_q.ac;
    old_q <= win_mem[pos_q];
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 10'd300; hys_q <= 10'd30; wlen_q <= 5'd8; alpha_q <= 16'd9830;
      mind_q <= 16'd20; maxd_q <= 16'd150; cool_q <= 16'd400; dco_q <= 10'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_THRESHOLD: thr_q   <= cfg_data_i[9:0];
        REG_HYST:      hys_q   <= cfg_data_i[9:0];
        REG_WLEN:      wlen_q  <= cfg_data_i[4:0];
        REG_ALPHA:     alpha_q <= cfg_data_i;
        REG_MIN_DUR:   mind_q  <= cfg_data_i;
        REG_MAX_DUR:   maxd_q  <= cfg_data_i;
        REG_COOLDOWN:  cool_q  <= cfg_data_i;
        REG_DC_OFFSET: dco_q   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (q_pop_o) it_q <= q_item_i;
      S_UPD: begin
        dvd_q  <= sum_new[SW-1] ? -sum_new : sum_new;
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= 6'(SW);
      end
      S_DIV: begin
        if (!trial[SW]) begin
          rem_q <= trial;
          quo_q <= {quo_q[SW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[SW-1:0], dvd_q[SW-1]};
          quo_q <= {quo_q[SW-2:0], 1'b0};
        end
        dvd_q  <= {dvd_q[SW-2:0], 1'b0};
        dcnt_q <= dcnt_q - 6'd1;
      end
      S_MUL: begin
        p1_q <= {27'd0, alpha_q} * {33'd0, quo_q[9:0]};
        p2_q <= {26'd0, (17'h10000 - {1'b0, alpha_q})} * {17'd0, env_q};
      end
      default: ;
    endcase
  end

  // sequencer and detector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; wvld_q <= '0; pos_q <= '0; sum_q <= '0; env_q <= '0;
      ph_q <= PH_IDLE; start_q <= '0; last_q <= '0; peak_q <= '0;
      total_q <= '0; len_q <= '0; relay_q <= 1'b0; tog_q <= 1'b0;
      ov_q <= 1'b0; od_q <= '0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (cfg_we_i) begin
        wvld_q <= '0; pos_q <= '0; sum_q <= '0;
      end
      case (state_q)
        S_IDLE: if (q_pop_o) begin
          if (q_item_i.mode == MODE_SAMPLE) begin
            state_q <= S_RD;
            if ({1'b0, pos_q} >= lenw) pos_q <= '0;
          end else begin
            tog_q <= (q_item_i.mode == MODE_TOGGLE) ||
                     ((q_item_i.mode == MODE_ON) != relay_q);
            if (q_item_i.mode == MODE_ON) relay_q <= 1'b1;
            else if (q_item_i.mode == MODE_OFF) relay_q <= 1'b0;
            else relay_q <= ~relay_q;
            last_q  <= q_item_i.now_ms;
            state_q <= S_OUT;
          end
        end
        S_RD: state_q <= S_UPD;
        S_UPD: begin
          sum_q <= sum_new;
          wvld_q[pos_q] <= 1'b1;
          pos_q <= ({1'b0, pos_q} + 1'b1 >= lenw) ? '0 : pos_q + 1'b1;
          state_q <= S_DIV;
        end
        S_DIV: if (dcnt_q == 6'd1) state_q <= S_MUL;
        S_MUL: state_q <= S_FSM;
        S_FSM: state_q <= S_OUT;
        S_OUT: begin
          ov_q    <= 1'b1;
          od_q    <= {tog_q, ph_q, lvl, relay_q};
          tog_q   <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      // new envelope from the product registers, then the phase machine
      if (state_q == S_FSM) begin : ph
        logic [25:0] e;
        logic [9:0]  l;
        e = 26'((({p1_q, 16'd0}) + {16'd0, p2_q}) >> 16);
        l = e[25:16];
        env_q <= e;
        case (ph_q)
          PH_IDLE: if ({1'b0, l} > hi) begin
            ph_q <= PH_DETECT; start_q <= it_q.now_ms;
            peak_q <= '0; total_q <= '0; len_q <= '0;
          end
          PH_DETECT: begin
            if (len_q != 16'hFFFF) begin
              len_q <= len_q + 16'd1; total_q <= total_q + {16'd0, l};
            end
            if (l > peak_q) peak_q <= l;
            if (l < lo) ph_q <= PH_VALID;
          end
          PH_VALID: begin
            if (dur < {16'd0, mind_q} || dur > {16'd0, maxd_q}) ph_q <= PH_IDLE;
            else if (age < {16'd0, cool_q}) ph_q <= PH_IDLE;
            else if (guard && cmp_ok) begin
              relay_q <= ~relay_q; last_q <= it_q.now_ms;
              ph_q <= PH_COOL; tog_q <= 1'b1;
            end else ph_q <= PH_IDLE;
          end
          default: if (age >= {16'd0, cool_q}) ph_q <= PH_IDLE;
        endcase
      end
    end
  end

endmodule

// ===== bench/clap_envelope_relay_trigger_tb.sv =====
// ----------------------------------------------------------------------------
// clap_envelope_relay_trigger_tb: self-checking bench for the clap detector
// Drives sample and manual items with random handshake gaps, predicts each
// result from a behavioral copy of the filter and phase machine, and
// compares every returned item field by field in order.
// ----------------------------------------------------------------------------
module clap_envelope_relay_trigger_tb;
  import cert_pkg::*;

  localparam int WINDOW_MAX = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ITEMS_TARGET = 1800;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = MODE_SAMPLE;
  logic [47:0] s_axis_tdata = '0;   // sample[9:0], now_ms[41:10], zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // relay_out, env_level[10:1], phase[12:11], toggled
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = REG_THRESHOLD;
  logic [15:0] cfg_data_i = '0;

  // expected result item
  typedef struct packed {
    logic       toggled;
    logic [1:0] phase;
    logic [9:0] env_level;
    logic       relay_out;
  } relay_result_t;

  relay_result_t expected_results[$];

  // shadow registers and detector state
  logic [9:0]  thr_q, hyst_q, dcoff_q;
  logic [4:0]  wlen_q;
  logic [15:0] alpha_q, min_dur_q, max_dur_q, cool_q;
  int          win_store[WINDOW_MAX];
  int unsigned win_pos;
  int          win_sum;
  logic [25:0] env_q;
  logic [1:0]  phase_q;
  logic [31:0] imp_start, last_change;
  int unsigned imp_peak, imp_total, imp_len;
  logic        relay_q;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] clock_ms;

  clap_envelope_relay_trigger #(.WINDOW_MAX(WINDOW_MAX)) dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_window();
    foreach (win_store[i]) win_store[i] = 0;
    win_pos = 0;
    win_sum = 0;
  endfunction

  function automatic void reset_detector();
    thr_q = 10'd300; hyst_q = 10'd30; wlen_q = 5'd8; alpha_q = 16'd9830;
    min_dur_q = 16'd20; max_dur_q = 16'd150; cool_q = 16'd400; dcoff_q = 10'd512;
    clear_window();
    env_q = '0; phase_q = PH_IDLE; imp_start = '0; imp_peak = 0;
    imp_total = 0; imp_len = 0; last_change = '0; relay_q = 1'b0;
  endfunction

  // filter one sample and advance the phase machine, returns toggle flag
  function automatic logic filter_sample(logic [9:0] raw, logic [31:0] now);
    int unsigned len;
    int ac, avg;
    int unsigned mag, lvl, hi, lo;
    logic [31:0] dur, age;
    longint unsigned mix;
    logic tog;
    tog = 1'b0;
    len = (wlen_q < 2) ? 2 : (wlen_q > WINDOW_MAX) ? WINDOW_MAX : wlen_q;
    ac = int'(raw) - int'(dcoff_q);
    if (win_pos >= len) win_pos = 0;
    win_sum -= win_store[win_pos];
    win_store[win_pos] = ac;
    win_sum += ac;
    avg = win_sum / int'(len);
    win_pos = (win_pos + 1) % len;
    mag = (avg < 0) ? -avg : avg;
    mix = longint'(alpha_q) * (longint'(mag) << 16)
        + longint'(65536 - int'(alpha_q)) * longint'(env_q);
    env_q = mix[41:16];
    lvl = env_q[25:16];
    hi = thr_q + hyst_q;
    lo = (thr_q > hyst_q) ? thr_q - hyst_q : 0;
    case (phase_q)
      PH_IDLE: begin
        if (lvl > hi) begin
          phase_q = PH_DETECT;
          imp_start = now;
          imp_peak = 0; imp_total = 0; imp_len = 0;
        end
      end
      PH_DETECT: begin
        if (imp_len < 65535) begin
          imp_len++;
          imp_total += lvl;
        end
        if (lvl > imp_peak) imp_peak = lvl;
        if (lvl < lo) phase_q = PH_VALID;
      end
      PH_VALID: begin
        dur = now - imp_start;
        age = now - last_change;
        if (dur < min_dur_q || dur > max_dur_q || age < cool_q) begin
          phase_q = PH_IDLE;
        end else if (longint'(imp_total) * 100 > longint'(imp_len) &&
                     2 * longint'(imp_peak) * longint'(imp_len) > 5 * longint'(imp_total)) begin
          relay_q = ~relay_q;
          last_change = now;
          phase_q = PH_COOL;
          tog = 1'b1;
        end else begin
          phase_q = PH_IDLE;
        end
      end
      default: begin
        age = now - last_change;
        if (age >= cool_q) phase_q = PH_IDLE;
      end
    endcase
    return tog;
  endfunction

  function automatic relay_result_t predict_relay(logic [1:0] mode, logic [9:0] raw,
                                                  logic [31:0] now);
    relay_result_t r;
    logic prev;
    prev = relay_q;
    if (mode == MODE_SAMPLE) begin
      r.toggled = filter_sample(raw, now);
    end else begin
      case (mode)
        MODE_ON:  relay_q = 1'b1;
        MODE_OFF: relay_q = 1'b0;
        default:  relay_q = ~relay_q;
      endcase
      last_change = now;
      r.toggled = (prev != relay_q);
    end
    r.relay_out = relay_q;
    r.env_level = env_q[25:16];
    r.phase = phase_q;
    return r;
  endfunction

  // send one item, predict its result at acceptance
  task automatic send_item(logic [1:0] mode, logic [9:0] raw, logic [31:0] now);
    int unsigned gap;
    if ($urandom_range(99) < send_idle) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {6'd0, now, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(predict_relay(mode, raw, now));
    items_sent++;
  endtask

  task automatic wait_drained();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // one register write, with cfg_we_i deasserted again before the task returns
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_THRESHOLD: thr_q = value[9:0];
      REG_HYST:      hyst_q = value[9:0];
      REG_WLEN:      wlen_q = value[4:0];
      REG_ALPHA:     alpha_q = value;
      REG_MIN_DUR:   min_dur_q = value;
      REG_MAX_DUR:   max_dur_q = value;
      REG_COOLDOWN:  cool_q = value;
      REG_DC_OFFSET: dcoff_q = value[9:0];
      default: ;
    endcase
    clear_window();
  endtask

  task automatic sample_at_step(logic [9:0] raw, int unsigned step_ms);
    clock_ms += step_ms;
    send_item(MODE_SAMPLE, raw, clock_ms);
  endtask

  // reset defaults, field extremes and every mode
  task automatic test_directed();
    send_item(MODE_SAMPLE, 10'd0, 32'd0);
    send_item(MODE_SAMPLE, 10'd1023, 32'hFFFF_FFFF);
    send_item(MODE_ON, 10'd1023, 32'h0000_0010);
    send_item(MODE_ON, 10'd0, 32'h8000_0000);
    send_item(MODE_OFF, 10'h2AA, 32'h5555_5555);
    send_item(MODE_OFF, 10'h155, 32'hAAAA_AAAA);
    send_item(MODE_TOGGLE, 10'd0, 32'd1);
    send_item(MODE_TOGGLE, 10'd512, 32'd2);
    // loud burst then quiet, crossing the default levels
    clock_ms = 32'd1000;
    repeat (10) sample_at_step(10'd1023, 1);
    repeat (12) sample_at_step(10'd512, 1);
  endtask

  // register extremes and the out-of-range window lengths
  task automatic test_register_extremes();
    logic [4:0] lens[6] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
    foreach (lens[i]) begin
      wait_drained();
      write_reg(REG_WLEN, {11'd0, lens[i]});
      write_reg(REG_ALPHA, (i % 2) ? 16'hFFFF : 16'd0);
      write_reg(REG_THRESHOLD, (i % 2) ? 16'd0 : 16'd1023);
      write_reg(REG_HYST, (i % 3 == 0) ? 16'd1023 : 16'd0);
      write_reg(REG_MIN_DUR, (i % 2) ? 16'd0 : 16'hFFFF);
      write_reg(REG_MAX_DUR, (i % 2) ? 16'hFFFF : 16'd0);
      write_reg(REG_COOLDOWN, (i % 2) ? 16'd0 : 16'hFFFF);
      write_reg(REG_DC_OFFSET, (i % 2) ? 16'd1023 : 16'd0);
      repeat (3) sample_at_step(10'($urandom_range(0, 1023)), 1);
      sample_at_step(10'd1023, 1);
      sample_at_step(10'd0, 1);
    end
  endtask

  task automatic random_config();
    write_reg(REG_THRESHOLD, 16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, 200)));
    write_reg(REG_HYST, 16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 60)));
    write_reg(REG_WLEN, 16'($urandom_range(0, 31)));
    write_reg(REG_ALPHA, 16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                                       : $urandom_range(4000, 40000)));
    write_reg(REG_MIN_DUR, 16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 15)));
    write_reg(REG_MAX_DUR, 16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                                         : $urandom_range(10, 120)));
    write_reg(REG_COOLDOWN, 16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 150)));
    write_reg(REG_DC_OFFSET, 16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
                                                           : $urandom_range(480, 540)));
  endtask

  // bursts over a quiet floor, with manual items and noise mixed in
  task automatic test_random_claps(int unsigned goal);
    int unsigned seg_end, amp, loud, quiet, k;
    while (items_sent < goal) begin
      wait_drained();
      random_config();
      seg_end = items_sent + 150;
      clock_ms = $urandom();
      while (items_sent < seg_end) begin
        k = $urandom_range(0, 19);
        if (k == 0) begin
          send_item(2'($urandom_range(1, 3)), 10'($urandom()), clock_ms + $urandom_range(0, 3));
        end else if (k == 1) begin
          repeat ($urandom_range(1, 8))
            send_item(2'($urandom()), 10'($urandom()), $urandom());
        end else begin
          amp = $urandom_range(0, 511);
          loud = $urandom_range(1, 20);
          quiet = $urandom_range(3, 30);
          repeat (loud)
            sample_at_step(10'(int'(dcoff_q) + (($urandom_range(0, 1)) ? int'(amp) : -int'(amp))),
                           $urandom_range(0, 15) == 0 ? $urandom_range(0, 400) : 1);
          repeat (quiet)
            sample_at_step(10'(int'(dcoff_q) + $urandom_range(0, 6) - 3),
                           $urandom_range(0, 15) == 0 ? $urandom_range(0, 400) : 1);
        end
      end
    end
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      relay_result_t exp_r, got_r;
      got_r = m_axis_tdata[13:0];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", m_axis_tdata);
      end else begin
        exp_r = expected_results.pop_front();
        if (got_r.relay_out !== exp_r.relay_out || got_r.env_level !== exp_r.env_level ||
            got_r.phase !== exp_r.phase || got_r.toggled !== exp_r.toggled) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: relay %b/%b env %0d/%0d phase %0d/%0d toggled %b/%b (exp/got)",
                     exp_r.relay_out, got_r.relay_out, exp_r.env_level, got_r.env_level,
                     exp_r.phase, got_r.phase, exp_r.toggled, got_r.toggled);
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    reset_detector();
    clock_ms = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    send_idle = 23; recv_idle = 81;
    test_random_claps(ITEMS_TARGET / 3);
    send_idle = 81; recv_idle = 23;
    test_random_claps(2 * ITEMS_TARGET / 3);
    send_idle = 0; recv_idle = 0;
    test_random_claps(ITEMS_TARGET);
    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
sv/cert_pkg.sv
sv/cert_front.sv
sv/cert_back.sv
sv/clap_envelope_relay_trigger.sv
bench/clap_envelope_relay_trigger_tb.sv
